>>> hw/rtl/pfr_pkg.sv
package pfr_pkg;

	localparam int NUM_COEF       = 7;
	localparam int COEF_W         = 16;
	localparam int IDX_W          = 3;
	localparam int ADDR_W         = 5;
	localparam int DATA_W         = 32;
	localparam int DEF_MAX_DEGREE = 6;
	localparam int DEF_COUNT_BITS = 16;
	localparam int SUMY_W         = 40;
	localparam int SUMSQ_W        = 64;
	localparam int WIDE_W         = 128;
	localparam int FRAC_BITS      = 12;

	typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_arr_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_ADD,
		F_SQR,
		F_SQY,
		F_ACC
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_ACC,
		B_CMP,
		B_DIV,
		B_OUT
	} back_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	function automatic logic [SUMSQ_W-1:0] addsat64(input logic [SUMSQ_W-1:0] a,
		input logic [SUMSQ_W-1:0] b);
		logic [SUMSQ_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUMSQ_W] ? '1 : s[SUMSQ_W-1:0];
	endfunction

endpackage

>>> hw/rtl/pfr_if.sv
interface pfr_point_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_sample;
	logic signed [15:0] y_sample;
	logic               last_point;

	modport source(output valid, x_sample, y_sample, last_point, input ready);
	modport sink(input valid, x_sample, y_sample, last_point, output ready);
endinterface

interface pfr_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] r_squared;
	logic               no_spread;

	modport source(output valid, r_squared, no_spread, input ready);
	modport sink(input valid, r_squared, no_spread, output ready);
endinterface

>>> hw/rtl/pfr_queue.sv
module pfr_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end
endmodule

>>> hw/rtl/pfr_front.sv
module pfr_front #(
	parameter int MAX_DEGREE = pfr_pkg::DEF_MAX_DEGREE,
	parameter int COUNT_BITS = pfr_pkg::DEF_COUNT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	pfr_point_if.sink                        point,
	input  pfr_pkg::coef_arr_t               coef,
	input  logic                             q_full,
	output logic                             q_push,
	output logic [COUNT_BITS-1:0]            job_count,
	output logic signed [pfr_pkg::SUMY_W-1:0] job_sum_y,
	output logic [pfr_pkg::SUMSQ_W-1:0]      job_sum_yy,
	output logic [pfr_pkg::SUMSQ_W-1:0]      job_sum_rr
);
	import pfr_pkg::*;

	front_state_t              state_q, state_d;
	logic signed [15:0]        x_q, y_q;
	logic                      last_q;
	logic signed [31:0]        acc_q;
	logic [IDX_W-1:0]          k_q;
	logic signed [65:0]        prod_q;
	logic signed [32:0]        mul_a, mul_b;
	logic [COUNT_BITS-1:0]     cnt_q, cnt_new;
	logic signed [SUMY_W-1:0]  sy_q, sy_new;
	logic signed [SUMY_W:0]    sy_sum;
	logic [SUMSQ_W-1:0]        syy_q, srr_q, syy_new;
	logic signed [32:0]        res_diff;
	logic signed [31:0]        res_sat;
	logic [31:0]               res_mag;
	logic signed [31:0]        horner_t, horner_n;
	logic                      accept;

	assign accept   = point.valid && point.ready;
	assign res_diff = 33'(y_q) - 33'(acc_q);
	assign res_sat  = sat32(66'(res_diff));
	assign res_mag  = res_sat[31] ? 32'(-33'(res_sat)) : 32'(res_sat);
	assign horner_t = sat32(prod_q >>> FRAC_BITS);
	assign horner_n = sat32(66'(33'(horner_t) + 33'($signed(coef[k_q]))));

	assign sy_sum  = (SUMY_W+1)'(sy_q) + (SUMY_W+1)'(y_q);
	assign sy_new  = (sy_sum[SUMY_W] != sy_sum[SUMY_W-1]) ?
		(sy_sum[SUMY_W] ? {1'b1, {(SUMY_W-1){1'b0}}} : {1'b0, {(SUMY_W-1){1'b1}}}) :
		sy_sum[SUMY_W-1:0];
	assign cnt_new = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
	assign syy_new = addsat64(syy_q, prod_q[SUMSQ_W-1:0]);

	assign job_count  = cnt_new;
	assign job_sum_y  = sy_new;
	assign job_sum_yy = syy_new;
	assign job_sum_rr = srr_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			F_MUL: begin
				mul_a = 33'(acc_q);
				mul_b = 33'(x_q);
			end
			F_SQR: begin
				mul_a = {1'b0, res_mag};
				mul_b = {1'b0, res_mag};
			end
			F_SQY: begin
				mul_a = 33'(y_q);
				mul_b = 33'(y_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) state_d = F_MUL;
			end
			F_MUL: state_d = F_ADD;
			F_ADD: begin
				state_d = (k_q == '0) ? F_SQR : F_MUL;
			end
			F_SQR: state_d = F_SQY;
			F_SQY: state_d = F_ACC;
			F_ACC: begin
				if (!last_q || !q_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		point.ready = (state_q == F_IDLE);
		q_push      = (state_q == F_ACC) && last_q && !q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			sy_q    <= '0;
			syy_q   <= '0;
			srr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_SQY) begin
				srr_q <= addsat64(srr_q, prod_q[SUMSQ_W-1:0]);
			end
			if (state_q == F_ACC && !last_q) begin
				cnt_q <= cnt_new;
				sy_q  <= sy_new;
				syy_q <= syy_new;
			end
			if (q_push) begin
				cnt_q <= '0;
				sy_q  <= '0;
				syy_q <= '0;
				srr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= point.x_sample;
			y_q    <= point.y_sample;
			last_q <= point.last_point;
			acc_q  <= 32'($signed(coef[MAX_DEGREE]));
			k_q    <= IDX_W'(MAX_DEGREE - 1);
		end
		if (state_q == F_ADD) begin
			acc_q <= horner_n;
			k_q   <= k_q - 1'b1;
		end
		if (state_q == F_MUL || state_q == F_SQR || state_q == F_SQY) begin
			prod_q <= mul_a * mul_b;
		end
	end
endmodule

>>> hw/rtl/pfr_back.sv
module pfr_back #(
	parameter int COUNT_BITS = pfr_pkg::DEF_COUNT_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  logic [COUNT_BITS-1:0]             job_count,
	input  logic signed [pfr_pkg::SUMY_W-1:0] job_sum_y,
	input  logic [pfr_pkg::SUMSQ_W-1:0]       job_sum_yy,
	input  logic [pfr_pkg::SUMSQ_W-1:0]       job_sum_rr,
	pfr_result_if.source                      result
);
	import pfr_pkg::*;

	back_state_t          state_q, state_d;
	logic [1:0]           j_q, p_q;
	logic [6:0]           cnt_q;
	logic [COUNT_BITS-1:0] n_q;
	logic [SUMY_W-1:0]    ymag_q;
	logic [SUMSQ_W-1:0]   syy_q, srr_q;
	logic [63:0]          prod_q;
	logic [WIDE_W-1:0]    acc_q, spread_q, sq_q, nq_q, rem_q, div_q;
	logic [WIDE_W-1:0]    pp_shift, acc_sum, rem_sh;
	logic [63:0]          op_a, op_b;
	logic [31:0]          pa, pb;
	logic                 rem_ge;
	logic                 ns_q;
	logic signed [31:0]   r2;
	logic                 out_load;
	logic                 out_valid_q;
	logic signed [31:0]   r_q;
	logic                 ns_out_q;

	always_comb begin
		case (j_q)
			2'd0: begin
				op_a = 64'(n_q);
				op_b = syy_q;
			end
			2'd1: begin
				op_a = 64'(ymag_q);
				op_b = 64'(ymag_q);
			end
			default: begin
				op_a = srr_q;
				op_b = 64'(n_q);
			end
		endcase
	end

	assign pa = p_q[1] ? op_a[63:32] : op_a[31:0];
	assign pb = p_q[0] ? op_b[63:32] : op_b[31:0];

	always_comb begin
		case (p_q)
			2'd0:    pp_shift = {64'b0, prod_q};
			2'd3:    pp_shift = {prod_q, 64'b0};
			default: pp_shift = {32'b0, prod_q, 32'b0};
		endcase
	end

	assign acc_sum = acc_q + pp_shift;
	assign rem_sh  = {rem_q[WIDE_W-2:0], nq_q[WIDE_W-1]};
	assign rem_ge  = (rem_sh >= div_q);

	always_comb begin
		if ((|nq_q[WIDE_W-1:32]) || (nq_q[31:0] > 32'h80001000)) begin
			r2 = 32'sh80000000;
		end else begin
			r2 = 32'(33'sd4096 - $signed({1'b0, nq_q[31:0]}));
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) state_d = B_MUL;
			end
			B_MUL: state_d = B_ACC;
			B_ACC: begin
				state_d = (p_q == 2'd3 && j_q == 2'd2) ? B_CMP : B_MUL;
			end
			B_CMP: begin
				state_d = (spread_q > sq_q) ? B_DIV : B_OUT;
			end
			B_DIV: begin
				if (cnt_q == 7'd127) state_d = B_OUT;
			end
			B_OUT: begin
				if (out_load) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == B_IDLE) && !q_empty;
		out_load = (state_q == B_OUT) && (!out_valid_q || result.ready);
	end

	assign result.valid     = out_valid_q;
	assign result.r_squared = r_q;
	assign result.no_spread = ns_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			n_q    <= job_count;
			ymag_q <= job_sum_y[SUMY_W-1] ? SUMY_W'(-job_sum_y) : job_sum_y;
			syy_q  <= job_sum_yy;
			srr_q  <= job_sum_rr;
			acc_q  <= '0;
			j_q    <= 2'd0;
			p_q    <= 2'd0;
		end
		if (state_q == B_MUL) begin
			prod_q <= pa * pb;
		end
		if (state_q == B_ACC) begin
			if (p_q == 2'd3) begin
				acc_q <= '0;
				p_q   <= 2'd0;
				j_q   <= j_q + 2'd1;
				case (j_q)
					2'd0:    spread_q <= acc_sum;
					2'd1:    sq_q     <= acc_sum;
					default: nq_q     <= acc_sum << FRAC_BITS;
				endcase
			end else begin
				acc_q <= acc_sum;
				p_q   <= p_q + 2'd1;
			end
		end
		if (state_q == B_CMP) begin
			ns_q  <= !(spread_q > sq_q);
			div_q <= spread_q - sq_q;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == B_DIV) begin
			rem_q <= rem_ge ? rem_sh - div_q : rem_sh;
			nq_q  <= {nq_q[WIDE_W-2:0], rem_ge};
			cnt_q <= cnt_q + 7'd1;
		end
		if (out_load) begin
			r_q      <= ns_q ? 32'sd0 : r2;
			ns_out_q <= ns_q;
		end
	end
endmodule

>>> hw/rtl/polynomial_fit_r_squared.sv
// Fit quality of a configured polynomial over a set of points.
// The coefficients of x^0 to x^6 are written over the APB port, at byte
// addresses 0 to 24. The user must write them only while no set is in
// progress; the block does not enforce it. Each transfer on the point
// channel carries x, y and a last flag. The front evaluates the polynomial
// by Horner's rule on one shared multiplier and accumulates sum y, sum y
// squared and the sum of squared residuals. It takes a new point only when
// idle, after the prior one has passed its Horner steps (a multiply and an
// add each), its residual square, y square and accumulation. A point marked
// last hands its sums to a two-entry queue, waiting while it is full, and
// clears them. The back then forms the products on a 32-bit multiplier and,
// when there is spread, runs a restoring division; short sets may follow
// back to back. The result sits in an output register until it is taken;
// while the receiver stalls, the back holds its next result and the front
// keeps accepting points until a last point finds the queue full.
// Reset clears the coefficients, front sums, the queue and output valid.
module polynomial_fit_r_squared #(
	parameter int MAX_DEGREE = pfr_pkg::DEF_MAX_DEGREE,
	parameter int COUNT_BITS = pfr_pkg::DEF_COUNT_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pfr_pkg::ADDR_W-1:0] paddr,
	input  logic [pfr_pkg::DATA_W-1:0] pwdata,
	output logic [pfr_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	pfr_point_if.sink                  point,
	pfr_result_if.source               result
);
	import pfr_pkg::*;

	localparam int JOB_W = COUNT_BITS + SUMY_W + 2 * SUMSQ_W;

	coef_arr_t                coef_q;
	logic [IDX_W-1:0]         reg_idx;
	logic                     idx_ok;
	logic                     q_push, q_pop, q_full, q_empty;
	logic [COUNT_BITS-1:0]    f_count, b_count;
	logic signed [SUMY_W-1:0] f_sum_y, b_sum_y;
	logic [SUMSQ_W-1:0]       f_sum_yy, f_sum_rr, b_sum_yy, b_sum_rr;
	logic [JOB_W-1:0]         q_din, q_dout;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign idx_ok  = (reg_idx < IDX_W'(NUM_COEF));
	assign pready  = 1'b1;
	assign prdata  = idx_ok ? DATA_W'($signed(coef_q[reg_idx])) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (psel && penable && pwrite && idx_ok) begin
			coef_q[reg_idx] <= pwdata[COEF_W-1:0];
		end
	end

	pfr_front #(
		.MAX_DEGREE(MAX_DEGREE),
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.point     (point),
		.coef      (coef_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.job_count (f_count),
		.job_sum_y (f_sum_y),
		.job_sum_yy(f_sum_yy),
		.job_sum_rr(f_sum_rr)
	);

	assign q_din = {f_count, f_sum_y, f_sum_yy, f_sum_rr};

	pfr_queue #(
		.W(JOB_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign {b_count, b_sum_y, b_sum_yy, b_sum_rr} = q_dout;

	pfr_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.job_count (b_count),
		.job_sum_y (b_sum_y),
		.job_sum_yy(b_sum_yy),
		.job_sum_rr(b_sum_rr),
		.result    (result)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("Queue push while full.");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("Queue pop while empty.");

	a_no_spread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.no_spread) |-> (result.r_squared == 32'sd0))
		else $error("Result without spread carries a nonzero value.");
endmodule
